>>> hw/rtl/brde_pkg.sv
`timescale 1ns / 1ps
// Package for the byte relative delta expander: widths, codes and the item
// type passed from the front end to the back end. No dependencies.
package brde_pkg;

    localparam int COUNT_BITS = 16;
    localparam int IDX_BITS   = COUNT_BITS + 1;
    localparam int VALUE_BITS = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] ESC_BYTE = 8'h80;

    // Escape byte counter values
    localparam logic [2:0] ESC_FULL = 3'd4;
    localparam logic [2:0] ESC_B1   = 3'd3;
    localparam logic [2:0] ESC_B2   = 3'd2;
    localparam logic [2:0] ESC_LAST = 3'd1;
    localparam logic [2:0] ESC_IDLE = 3'd0;

    // Configuration register indexes
    localparam logic CFG_SKIP_COUNT = 1'b0;
    localparam logic CFG_OUT_COUNT  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SHORT     = 2'd1;
    localparam logic [1:0] STATUS_ESC_TRUNC = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE,   // escape marker or gathered escape byte: nothing decoded
        KIND_DELTA,  // operand is a sign-extended delta
        KIND_ABS     // operand is a completed absolute value
    } item_kind_t;

    typedef struct packed {
        item_kind_t              kind;
        logic [VALUE_BITS-1:0]   operand;
        logic                    last;
        logic                    in_escape;  // escape still open after this byte
    } queue_item_t;

endpackage

>>> hw/rtl/brde_front.sv
`timescale 1ns / 1ps
// Front end: tracks escape sequences and classifies each input byte.
// Depends on brde_pkg.
module brde_front
    import brde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        block_end,
    output queue_item_t item
);

    logic [2:0]  esc_left_reg, esc_left_next;
    logic [23:0] gather_reg, gather_next;

    always_comb
    begin
        esc_left_next = esc_left_reg;
        gather_next   = gather_reg;
        item.kind     = KIND_NONE;
        item.operand  = '0;
        item.last     = block_end;

        if (esc_left_reg != ESC_IDLE)
        begin
            esc_left_next = esc_left_reg - 3'd1;
            case (esc_left_reg)
                ESC_FULL: gather_next[7:0]   = data_byte;
                ESC_B1:   gather_next[15:8]  = data_byte;
                ESC_B2:   gather_next[23:16] = data_byte;
                ESC_LAST:
                begin
                    item.kind    = KIND_ABS;
                    item.operand = {data_byte, gather_reg};
                    gather_next  = '0;
                end
                default:  gather_next = gather_reg;
            endcase
        end
        else if (data_byte == ESC_BYTE)
        begin
            esc_left_next = ESC_FULL;
            gather_next   = '0;
        end
        else
        begin
            item.kind    = KIND_DELTA;
            item.operand = {{(VALUE_BITS-8){data_byte[7]}}, data_byte};
        end

        item.in_escape = (esc_left_next != ESC_IDLE);

        // The block's state clears after its final byte.
        if (block_end)
        begin
            esc_left_next = ESC_IDLE;
            gather_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_left_reg <= ESC_IDLE;
            gather_reg   <= '0;
        end
        else if (accept)
        begin
            esc_left_reg <= esc_left_next;
            gather_reg   <= gather_next;
        end
    end

endmodule

>>> hw/rtl/brde_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of classified items between the front and back ends.
// Depends on brde_pkg.
module brde_queue
    import brde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  queue_item_t push_item,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output queue_item_t head_item
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    queue_item_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0]  count_reg;

    assign full      = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_BITS'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_BITS'(1);
                2'b01:   count_reg <= count_reg - CNT_BITS'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> hw/rtl/brde_back.sv
`timescale 1ns / 1ps
// Back end: running value, decoded count, output window and the result
// register. Depends on brde_pkg.
module brde_back
    import brde_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [COUNT_BITS-1:0] skip_count,
    input  logic [COUNT_BITS-1:0] out_count,
    input  logic                  item_valid,
    input  queue_item_t           item,
    output logic                  item_pop,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [VALUE_BITS-1:0] res_value,
    output logic                  res_value_valid,
    output logic                  res_last,
    output logic [1:0]            res_status
);

    localparam logic [IDX_BITS-1:0] IDX_MAX = '1;

    logic [VALUE_BITS-1:0] running_reg, running_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic                  done_reg, done_next;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic                  out_vvalid_reg, out_last_reg;
    logic [1:0]            out_status_reg;

    logic                  decoded, emit, finish, has_result;
    logic [IDX_BITS-1:0]   total;
    logic [VALUE_BITS-1:0] new_value;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_vvalid, r_last;
    logic [1:0]            r_status;

    assign item_pop = item_valid && (!out_valid_reg || res_ready);

    always_comb
    begin
        total     = {1'b0, skip_count} + {1'b0, out_count};
        decoded   = !done_reg && (item.kind != KIND_NONE);
        new_value = (item.kind == KIND_DELTA) ? running_reg + item.operand : item.operand;
        emit      = decoded && (idx_reg >= {1'b0, skip_count}) && (idx_reg < total);
        finish    = emit && ((idx_reg + IDX_BITS'(1)) == total);

        r_value    = new_value;
        r_vvalid   = 1'b1;
        r_last     = finish;
        r_status   = STATUS_OK;
        has_result = emit;
        if (!done_reg && item.last && !finish)
        begin
            has_result = 1'b1;
            r_last     = 1'b1;
            if (item.in_escape)
            begin
                r_value  = '0;
                r_vvalid = 1'b0;
                r_status = STATUS_ESC_TRUNC;
            end
            else
            begin
                r_value  = emit ? new_value : '0;
                r_vvalid = emit;
                r_status = STATUS_SHORT;
            end
        end

        running_next = running_reg;
        idx_next     = idx_reg;
        done_next    = done_reg;
        if (item.last)
        begin
            running_next = '0;
            idx_next     = '0;
            done_next    = 1'b0;
        end
        else if (decoded)
        begin
            running_next = new_value;
            if (idx_reg != IDX_MAX)
            begin
                idx_next = idx_reg + IDX_BITS'(1);
            end
            if (finish)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= '0;
            idx_reg       <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_pop)
            begin
                running_reg   <= running_next;
                idx_reg       <= idx_next;
                done_reg      <= done_next;
                out_valid_reg <= has_result;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop && has_result)
        begin
            out_value_reg  <= r_value;
            out_vvalid_reg <= r_vvalid;
            out_last_reg   <= r_last;
            out_status_reg <= r_status;
        end
    end

    assign res_valid       = out_valid_reg;
    assign res_value       = out_value_reg;
    assign res_value_valid = out_vvalid_reg;
    assign res_last        = out_last_reg;
    assign res_status      = out_status_reg;

endmodule

>>> hw/rtl/byte_relative_delta_expander_unit.sv
`timescale 1ns / 1ps
// Top level of the byte relative delta expander: configuration registers and
// the front end, queue and back end. Depends on brde_pkg and the brde modules.
//
// Usage: compressed bytes enter on the s_ channel, one byte per transfer, with
// s_tlast marking the final byte of a compressed block. Each delta byte or
// completed four-byte escape decodes one 32-bit value; the values inside the
// window set by skip_count and out_count leave on the m_ channel, one per
// transfer. A block that ends early or inside an escape gives a final
// transfer with m_tlast set and an error status in m_tuser.
// The front end classifies each byte in the cycle of its transfer and writes
// it to a two-entry queue; the back end takes one item a cycle from the queue
// into the result register whenever that register is empty or being taken.
// A result passes through the queue and then the result register before it
// shows on m_tvalid; throughput is one byte per cycle while the receiver
// takes every result. When the receiver stalls, the result register holds
// and the queue fills, after which s_tready falls; nothing is dropped.
// Reset clears the decoding state, empties the queue and sets skip_count to 0
// and out_count to 1. Configuration writes take effect at the next edge and
// are meant for times when the block holds no work.
module byte_relative_delta_expander_unit
    import brde_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // block_end
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [VALUE_BITS-1:0] m_tdata,   // [31:0] value
    output logic                  m_tlast,   // res_last
    output logic [2:0]            m_tuser,   // [0] value_valid, [2:1] status
    // Configuration write port
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [COUNT_BITS-1:0] cfg_wdata
);

    logic [COUNT_BITS-1:0] skip_count_reg;
    logic [COUNT_BITS-1:0] out_count_reg;

    logic        in_accept;
    logic        q_full, q_not_empty, q_pop;
    queue_item_t front_item, head_item;
    logic        res_value_valid;
    logic [1:0]  res_status;

    // Configuration registers: the write lands on the edge where cfg_we is high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_count_reg <= '0;
            out_count_reg  <= COUNT_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SKIP_COUNT: skip_count_reg <= cfg_wdata;
                CFG_OUT_COUNT:  out_count_reg  <= cfg_wdata;
                default:        skip_count_reg <= skip_count_reg;
            endcase
        end
    end

    // An input transfer happens whenever s_tvalid is high and the queue has room.
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    brde_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (s_tdata),
        .block_end (s_tlast),
        .item      (front_item)
    );

    brde_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    brde_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .skip_count      (skip_count_reg),
        .out_count       (out_count_reg),
        .item_valid      (q_not_empty),
        .item            (head_item),
        .item_pop        (q_pop),
        .res_valid       (m_tvalid),
        .res_ready       (m_tready),
        .res_value       (m_tdata),
        .res_value_valid (res_value_valid),
        .res_last        (m_tlast),
        .res_status      (res_status)
    );

    assign m_tuser = {res_status, res_value_valid};

endmodule
